[src/anp_pkg.sv]
`timescale 1ns / 1ps

package anp_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

  // Base mode register codes.
  localparam logic [1:0] ModeAuto = 2'd0;
  localparam logic [1:0] ModeDec  = 2'd1;
  localparam logic [1:0] ModeHex  = 2'd2;

  // Configuration register indexes.
  localparam logic RegTerminator = 1'b0;
  localparam logic RegBaseMode   = 1'b1;

  localparam int unsigned ValueW = 32;

  // Hex digit value; characters that are no hex digit give their raw code.
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = c - ChUpA + 8'd10;
    end else if (c >= ChLowA && c <= ChLowF) begin
      d = c - ChLowA + 8'd10;
    end
    return d;
  endfunction

endpackage

[src/ascii_number_parser.sv]
`timescale 1ns / 1ps

// Streaming ASCII number parser.
// Characters enter one per item on the input channel (in_valid_i / in_ready_o,
// in_character_i). They are folded into a 32-bit accumulator until a character
// equal to the terminator register arrives; that item produces one result item
// on the output channel (out_valid_o / out_ready_i) carrying the value, negated
// if the string began with a minus, and a flag telling whether it was parsed
// as hexadecimal. All other characters produce no result.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) sets the
// terminator (index 0) and the base mode (index 1: auto, decimal, hex; the
// unused code acts as auto). Writes take effect at once and are meant for
// idle periods only.
// Every item is handled in the cycle in which it is accepted, so the block
// takes one character per cycle while in_ready_o is high; the output register
// holds the result in the cycle after the terminator is accepted. It is the only
// buffer: while it holds a result that the receiver stalls on, in_ready_o is
// low, and it is high again in the cycle the result is taken.
// Reset clears the string state, the configuration and the output valid bit.
module ascii_number_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_character_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_value_o,
  output logic               out_was_hex_o
);

  localparam int unsigned W = anp_pkg::ValueW;

  // Configuration registers.
  logic [7:0] terminator_q;
  logic [1:0] base_mode_q;

  // String state.
  logic [W-1:0] acc_q, acc_d;
  logic         negative_q, negative_d;
  logic [1:0]   position_q, position_d;
  logic         first_zero_q, first_zero_d;
  logic         hex_active_q, hex_active_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_value_q;
  logic         out_hex_q;

  logic         accept;
  logic         term_match;
  logic         auto_mode;
  logic         decode_hex;
  logic         prefix_x;
  logic         sign_char;
  logic [W-1:0] acc_x10;
  logic [W-1:0] acc_x16;
  logic [W-1:0] dec_digit;
  logic [W-1:0] hex_value;
  logic [W-1:0] result_value;

  // The output register parts the channels: a new character is taken as soon
  // as any pending result leaves.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign term_match = (in_character_i == terminator_q);
  assign auto_mode  = (base_mode_q != anp_pkg::ModeDec) && (base_mode_q != anp_pkg::ModeHex);
  assign decode_hex = (base_mode_q == anp_pkg::ModeHex) || (auto_mode && hex_active_q);

  // "0x" as the first two characters switches auto mode to hexadecimal.
  assign prefix_x  = auto_mode && (position_q == 2'd1) && first_zero_q &&
                     (in_character_i == anp_pkg::ChX);
  // A leading minus only counts where decimal parsing is possible.
  assign sign_char = (position_q == 2'd0) && (in_character_i == anp_pkg::ChMinus) &&
                     (base_mode_q != anp_pkg::ModeHex);

  // Multiply by ten as shift-and-add; digits are not checked, so a non-digit
  // contributes its code minus the code of '0', wrapping modulo 2^32.
  assign acc_x10   = {acc_q[W-4:0], 3'b000} + {acc_q[W-2:0], 1'b0};
  assign acc_x16   = {acc_q[W-5:0], 4'b0000};
  assign dec_digit = {{(W-8){1'b0}}, in_character_i} - {{(W-8){1'b0}}, anp_pkg::ChZero};
  assign hex_value = {{(W-8){1'b0}}, anp_pkg::hex_digit(in_character_i)};

  assign result_value = negative_q ? (~acc_q + {{(W-1){1'b0}}, 1'b1}) : acc_q;

  always_comb begin
    acc_d        = acc_q;
    negative_d   = negative_q;
    position_d   = position_q;
    first_zero_d = first_zero_q;
    hex_active_d = hex_active_q;
    if (accept) begin
      if (term_match) begin
        // End of string: the state starts over for the next one.
        acc_d        = '0;
        negative_d   = 1'b0;
        position_d   = 2'd0;
        first_zero_d = 1'b0;
        hex_active_d = 1'b0;
      end else begin
        priority if (prefix_x) begin
          hex_active_d = 1'b1;
          acc_d        = '0;
        end else if (sign_char) begin
          negative_d = 1'b1;
        end else if (decode_hex) begin
          acc_d = acc_x16 + hex_value;
        end else begin
          acc_d = acc_x10 + dec_digit;
        end
        if (position_q == 2'd0 && in_character_i == anp_pkg::ChZero) begin
          first_zero_d = 1'b1;
        end
        if (position_q != 2'd2) begin
          position_d = position_q + 2'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && term_match) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terminator_q <= '0;
      base_mode_q  <= anp_pkg::ModeAuto;
      acc_q        <= '0;
      negative_q   <= 1'b0;
      position_q   <= 2'd0;
      first_zero_q <= 1'b0;
      hex_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          anp_pkg::RegTerminator: terminator_q <= cfg_data_i;
          anp_pkg::RegBaseMode:   base_mode_q  <= cfg_data_i[1:0];
          default:                terminator_q <= terminator_q;
        endcase
      end
      acc_q        <= acc_d;
      negative_q   <= negative_d;
      position_q   <= position_d;
      first_zero_q <= first_zero_d;
      hex_active_q <= hex_active_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload; loaded only when a terminator is accepted.
  always_ff @(posedge clk_i) begin
    if (accept && term_match) begin
      out_value_q <= result_value;
      out_hex_q   <= decode_hex;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = $signed(out_value_q);
  assign out_was_hex_o = out_hex_q;

`ifndef SYNTHESIS
  // A result only appears after a terminator was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept && term_match))
    else $error("result raised without an accepted terminator");

  // A terminator leaves the string state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && term_match) |=>
      (acc_q == '0 && !negative_q && position_q == 2'd0 && !hex_active_q))
    else $error("string state not cleared after terminator");

  // The character position saturates at two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_q != 2'd3)
    else $error("position counter overran");

  // The hex prefix can only have been taken after a leading zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_active_q |-> first_zero_q)
    else $error("hex mode active without leading zero");
`endif

endmodule

[tb/sv/tb_ascii_number_parser.sv]
`timescale 1ns / 1ps

// Self-checking testbench for the streaming ASCII number parser.
module tb_ascii_number_parser;

  // The base mode register has one unused code; the block treats it as auto.
  localparam logic [1:0] ModeSpare = 2'd3;

  // Random part: eight phases, each with its own configuration and idling.
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 220;
  // Cycles to wait once every result is in. A result is registered in the cycle
  // after its terminator is accepted; the wait covers anything still in the block.
  localparam int unsigned SettleCycles  = 4;
  // A correct run never goes this long without an item moving on either channel.
  localparam int unsigned StallLimit    = 2000;

  typedef enum logic [1:0] {RowChar, RowTerm, RowMode} row_kind_e;

  // One row of the directed table. A character row may carry a typed result,
  // which then replaces the one that the predictor works out.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        typed;
    logic [31:0] value;
    logic        was_hex;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic        was_hex;
  } number_t;

  // The directed part starts from the reset configuration: terminator 0, auto.
  localparam int unsigned NumDirRows = 34;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // An empty string right after reset gives zero.
    '{RowChar, 8'h00,                    1'b1, 32'd0,   1'b0},
    // "0xFf" in auto mode switches to hex: 0xFF.
    '{RowChar, anp_pkg::ChZero,          1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChX,             1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChUpF,           1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChLowF,          1'b0, 32'd0,   1'b0},
    '{RowChar, 8'h00,                    1'b1, 32'd255, 1'b1},
    // "-0x" stays decimal, so the 'x' and the byte 0xFF are plain non-digits.
    '{RowChar, anp_pkg::ChMinus,         1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChZero,          1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChX,             1'b0, 32'd0,   1'b0},
    '{RowChar, 8'hFF,                    1'b0, 32'd0,   1'b0},
    '{RowChar, 8'h00,                    1'b0, 32'd0,   1'b0},
    // With 'x' as terminator the hex prefix can never be seen.
    '{RowTerm, anp_pkg::ChX,             1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChZero,          1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChX,             1'b1, 32'd0,   1'b0},
    // A minus terminator ends the string before it can act as a sign.
    '{RowTerm, anp_pkg::ChMinus,         1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChMinus,         1'b1, 32'd0,   1'b0},
    // Decimal mode: a lone minus gives zero.
    '{RowTerm, 8'hFF,                    1'b0, 32'd0,   1'b0},
    '{RowMode, {6'd0, anp_pkg::ModeDec}, 1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChMinus,         1'b0, 32'd0,   1'b0},
    '{RowChar, 8'hFF,                    1'b1, 32'd0,   1'b0},
    // Hex mode: a leading minus and a 'g' both add their raw codes.
    '{RowMode, {6'd0, anp_pkg::ModeHex}, 1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChMinus,         1'b0, 32'd0,   1'b0},
    '{RowChar, 8'h67,                    1'b0, 32'd0,   1'b0},
    '{RowChar, 8'hFF,                    1'b0, 32'd0,   1'b0},
    // The sign is taken in decimal, then the mode turns to hex mid-string:
    // the rest is read as hex and the result is still negated.
    '{RowMode, {6'd0, anp_pkg::ModeDec}, 1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChMinus,         1'b0, 32'd0,   1'b0},
    '{RowChar, 8'h31,                    1'b0, 32'd0,   1'b0},
    '{RowMode, {6'd0, anp_pkg::ModeHex}, 1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChUpA,           1'b0, 32'd0,   1'b0},
    '{RowChar, 8'hFF,                    1'b0, 32'd0,   1'b0},
    // The unused mode code acts as auto: "0x" alone gives hex zero.
    '{RowMode, {6'd0, ModeSpare},        1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChZero,          1'b0, 32'd0,   1'b0},
    '{RowChar, anp_pkg::ChX,             1'b0, 32'd0,   1'b0},
    '{RowChar, 8'hFF,                    1'b1, 32'd0,   1'b1}
  };

  // Every input of the block is known from time zero.
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_index_i    = 1'b0;
  logic [7:0]         cfg_data_i     = 8'd0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [7:0]         in_character_i = 8'd0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic signed [31:0] out_value_o;
  logic               out_was_hex_o;

  // Predictor copy of the configuration and the string state, at reset values.
  logic [7:0]  term_cfg    = 8'd0;
  logic [1:0]  mode_cfg    = anp_pkg::ModeAuto;
  logic [31:0] acc         = 32'd0;
  logic        minus_seen  = 1'b0;
  logic [1:0]  chars_taken = 2'd0;
  logic        lead_zero   = 1'b0;
  logic        hex_seen    = 1'b0;

  // Parsed numbers that the block still owes, oldest first.
  number_t     pending_numbers[$];
  number_t     due;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned error_count    = 0;

  ascii_number_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_character_i (in_character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .out_was_hex_o  (out_was_hex_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Folds one accepted character into the predicted string state. Returns 1
  // when the character is the terminator, with the finished number in result.
  function automatic logic fold_character(input logic [7:0] c, output number_t result);
    logic        auto_mode;
    logic        hex_now;
    logic [31:0] digit;
    auto_mode = (mode_cfg != anp_pkg::ModeDec) && (mode_cfg != anp_pkg::ModeHex);
    hex_now   = (mode_cfg == anp_pkg::ModeHex) || (auto_mode && hex_seen);
    result    = '0;
    // The terminator wins over every other meaning a character could have.
    if (c == term_cfg) begin
      result.value   = minus_seen ? 32'd0 - acc : acc;
      result.was_hex = hex_now;
      acc         = 32'd0;
      minus_seen  = 1'b0;
      chars_taken = 2'd0;
      lead_zero   = 1'b0;
      hex_seen    = 1'b0;
      return 1'b1;
    end
    if (auto_mode && chars_taken == 2'd1 && lead_zero && c == anp_pkg::ChX) begin
      hex_seen = 1'b1;
      acc      = 32'd0;
    end else if (chars_taken == 2'd0 && c == anp_pkg::ChMinus &&
                 mode_cfg != anp_pkg::ModeHex) begin
      minus_seen = 1'b1;
    end else if (hex_now) begin
      // Anything that is no hex digit is added with its own code.
      digit = {24'd0, c};
      if (c >= anp_pkg::ChZero && c <= anp_pkg::ChNine) begin
        digit = digit - anp_pkg::ChZero;
      end else if (c >= anp_pkg::ChUpA && c <= anp_pkg::ChUpF) begin
        digit = digit - anp_pkg::ChUpA + 32'd10;
      end else if (c >= anp_pkg::ChLowA && c <= anp_pkg::ChLowF) begin
        digit = digit - anp_pkg::ChLowA + 32'd10;
      end
      acc = (acc << 4) + digit;
    end else begin
      // Decimal takes any character as its code minus that of '0', wrapped.
      acc = acc * 32'd10 + {24'd0, c} - {24'd0, anp_pkg::ChZero};
    end
    if (chars_taken == 2'd0 && c == anp_pkg::ChZero) begin
      lead_zero = 1'b1;
    end
    if (chars_taken != 2'd2) begin
      chars_taken = chars_taken + 2'd1;
    end
    return 1'b0;
  endfunction

  // Offers one character, with random idle cycles in front of it as the
  // current phase asks, and records what the block owes once it is accepted.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic typed = 1'b0,
                           input number_t typed_number = '0);
    number_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    in_character_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    if (fold_character(c, predicted)) begin
      pending_numbers.push_back(typed ? typed_number : predicted);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stops the sender and waits until every owed number has come out, then waits
  // SettleCycles more for the output register to settle.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_numbers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(input logic idx, input logic [7:0] data);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    if (idx == anp_pkg::RegTerminator) begin
      term_cfg = data;
    end else begin
      mode_cfg = data[1:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) begin
      return anp_pkg::ChZero + 8'(v);
    end
    return ($urandom_range(1) ? anp_pkg::ChUpA : anp_pkg::ChLowA) + 8'(v - 10);
  endfunction

  // Most strings are well formed: an optional sign or hex prefix, digits of
  // the matching kind and the terminator. A few are long enough to wrap.
  // The rest is raw noise or strings with signs and prefixes in odd places.
  task automatic send_random_string();
    int unsigned kind;
    int unsigned digits;
    logic        hex_body;
    kind = $urandom_range(99);
    if (kind < 80) begin
      hex_body = (mode_cfg == anp_pkg::ModeHex);
      if (mode_cfg != anp_pkg::ModeHex && $urandom_range(3) == 0) begin
        send_char(anp_pkg::ChMinus);
      end else if (mode_cfg != anp_pkg::ModeHex && mode_cfg != anp_pkg::ModeDec &&
                   $urandom_range(1)) begin
        send_char(anp_pkg::ChZero);
        send_char(anp_pkg::ChX);
        hex_body = 1'b1;
      end
      digits = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(1, 6);
      repeat (digits) begin
        send_char(hex_body ? hex_char() : anp_pkg::ChZero + 8'($urandom_range(9)));
      end
      send_char(term_cfg);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(4))
          0: send_char(anp_pkg::ChMinus);
          1: send_char(anp_pkg::ChZero);
          2: send_char(anp_pkg::ChX);
          3: send_char(hex_char());
          default: send_char(8'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(1)) begin
        send_char(term_cfg);
      end
    end
  endtask

  // The receiver decides at each falling edge whether it takes a result.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result taken is checked against the oldest owed number.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_numbers.size() == 0) begin
        $display("%0t: unexpected result: value %0d was_hex %0b",
                 $time, out_value_o, out_was_hex_o);
        error_count++;
      end else begin
        due = pending_numbers.pop_front();
        if (out_value_o !== due.value) begin
          $display("%0t: value mismatch: expected %0d, got %0d",
                   $time, $signed(due.value), out_value_o);
          error_count++;
        end
        if (out_was_hex_o !== due.was_hex) begin
          $display("%0t: was_hex mismatch: expected %0b, got %0b",
                   $time, due.was_hex, out_was_hex_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long is a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("%0t: nothing accepted for %0d cycles, %0d results still due",
                 $time, StallLimit, pending_numbers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned phase_start;
    logic [7:0]  term_pick;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, without idling on either side.
    for (row = 0; row < NumDirRows; row++) begin
      case (DirRows[row].kind)
        RowTerm: write_reg(anp_pkg::RegTerminator, DirRows[row].data);
        RowMode: write_reg(anp_pkg::RegBaseMode, DirRows[row].data);
        default: send_char(DirRows[row].data, DirRows[row].typed,
                           '{DirRows[row].value, DirRows[row].was_hex});
      endcase
    end

    // Random part. The idling pattern cycles through none, sender only,
    // receiver only and both; the mode walks through all four codes twice in a
    // different order, and the terminator takes both extremes before going
    // random. A string left open at the end of a phase sees the new settings.
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      if (phase == 0) begin
        term_pick = 8'h00;
      end else if (phase == 1) begin
        term_pick = 8'hFF;
      end else begin
        term_pick = 8'($urandom_range(255));
      end
      write_reg(anp_pkg::RegTerminator, term_pick);
      // The upper data bits are random; only the low two bits hold the mode.
      write_reg(anp_pkg::RegBaseMode,
                {6'($urandom_range(63)), 2'((phase + phase / 4) % 4)});
      phase_start = items_sent;
      while (items_sent - phase_start < ItemsPerPhase) begin
        send_random_string();
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
